[sv/elementary_automaton_sequencer_core_macros.svh]
// assertion macros used by the checker file
`ifndef ELEMENTARY_AUTOMATON_SEQUENCER_CORE_MACROS_SVH
`define ELEMENTARY_AUTOMATON_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define EAS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eas: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define EAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eas: next-cycle check failed");

`endif

[sv/eas_pkg.sv]
package eas_pkg;

    // default geometry
    localparam int COLUMNS_DEFAULT        = 64;
    localparam int ROWS_DEFAULT           = 256;
    localparam int CHANNELS_DEFAULT       = 16;
    localparam int MAX_ITERATIONS_DEFAULT = 1000;

    // register widths
    localparam int RULE_W      = 8;
    localparam int INIT_ROW_W  = 64;
    localparam int ITER_W      = 10;
    localparam int FRAME_X_W   = 7;
    localparam int FRAME_Y_W   = 9;
    localparam int FRAME_W_W   = 7;
    localparam int FRAME_H_W   = 9;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [RULE_W-1:0] RULE_RESET = 8'd30;

    // divider operand width for the small side
    localparam int DIVISOR_W = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RULE       = 3'd0,
        REG_INIT_ROW   = 3'd1,
        REG_SHORT_RING = 3'd2,
        REG_ITERATIONS = 3'd3,
        REG_FRAME_X    = 3'd4,
        REG_FRAME_Y    = 3'd5,
        REG_FRAME_W    = 3'd6,
        REG_FRAME_H    = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_GENERATE = 3'd0,
        KIND_FLIP_H   = 3'd1,
        KIND_FLIP_V   = 3'd2,
        KIND_RESTART  = 3'd3,
        KIND_SAMPLE   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] channel;
        logic       clock_high;
        logic [4:0] channel_count;
    } item_t;

    typedef struct packed {
        logic [3:0] out_channel;
        logic       gate;
        logic       trigger;
        logic       end_of_sequence;
    } result_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_GEN_INIT,
        OP_GEN_STEP,
        OP_FH_READ,
        OP_FH_WRITE,
        OP_FV_READ_A,
        OP_FV_READ_B,
        OP_FV_WRITE_A,
        OP_FV_WRITE_B,
        OP_RS_ZERO,
        OP_RS_DIV,
        OP_RS_TAKE,
        OP_RS_POS,
        OP_SM_DIV,
        OP_SM_TAKE,
        OP_SM_STEP,
        OP_POS_DIV,
        OP_SM_READ,
        OP_SM_BIT,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic gen_last;
        logic row_last;
        logic pair_last;
        logic count_zero;
        logic div_busy;
        logic chan_last;
        logic sample_ok;
        logic frame_empty;
    } dp_status_t;

endpackage

[sv/elementary_automaton_sequencer_core.sv]
// generate: min(iterations, MAX_ITERATIONS) + 1 passes over all ROWS rows, one row per cycle
// flip horizontal: each row read, then written back reversed; flip vertical: each mirrored row pair read, then swapped
// restart: one divide by the serial divider, then one start position per active channel
// clock sample: up to two divides by the serial divider plus any output stall, one at a time
// reset clears all control state; the cell field reads as zero until the first generate
// and needs no clearing pass
module elementary_automaton_sequencer_core #(
    parameter int COLUMNS        = eas_pkg::COLUMNS_DEFAULT,
    parameter int ROWS           = eas_pkg::ROWS_DEFAULT,
    parameter int CHANNELS       = eas_pkg::CHANNELS_DEFAULT,
    parameter int MAX_ITERATIONS = eas_pkg::MAX_ITERATIONS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [eas_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [eas_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  eas_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output eas_pkg::result_t                result
);
    import eas_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing
    eas_controller u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // field, channels and arithmetic
    eas_datapath #(
        .COLUMNS        (COLUMNS),
        .ROWS           (ROWS),
        .CHANNELS       (CHANNELS),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

[sv/eas_divider.sv]
module eas_divider #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // one restoring step per cycle
    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= diff[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[sv/eas_datapath.sv]
module eas_datapath #(
    parameter int COLUMNS        = 64,
    parameter int ROWS           = 256,
    parameter int CHANNELS       = 16,
    parameter int MAX_ITERATIONS = 1000
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [eas_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [eas_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  eas_pkg::item_t                       item,
    input  eas_pkg::dp_cmd_t                     cmd,
    output eas_pkg::dp_status_t                  status,
    output eas_pkg::result_t                     result
);
    import eas_pkg::*;

    localparam int ROW_AW = $clog2(ROWS);
    localparam int COL_AW = $clog2(COLUMNS);
    localparam int XW     = $clog2(COLUMNS + 1);
    localparam int YW     = $clog2(ROWS + 1);
    localparam int AREA_W = $clog2(COLUMNS * ROWS + 1);
    localparam int POS_W  = $clog2(COLUMNS * ROWS);
    localparam int SUM_W  = AREA_W + 1;
    localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(CHANNELS + 1);
    localparam int PASS_W = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS + 1) : 1;
    localparam int COL_SUM_W = DIVISOR_W + 1;

    // configuration registers
    logic [RULE_W-1:0]    rule_reg;
    logic [INIT_ROW_W-1:0] init_row_reg;
    logic                 short_ring_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic [FRAME_X_W-1:0] frame_x_reg;
    logic [FRAME_Y_W-1:0] frame_y_reg;
    logic [FRAME_W_W-1:0] frame_w_reg;
    logic [FRAME_H_W-1:0] frame_h_reg;

    // field store and row engine
    logic [COLUMNS-1:0] field_mem [ROWS];
    logic [COLUMNS-1:0] rd_data_reg;
    logic [COLUMNS-1:0] rd_val;
    logic               field_ok_reg;
    logic [COLUMNS-1:0] row_work_reg;
    logic [COLUMNS-1:0] hold_reg;
    logic [ROW_AW-1:0]  row_cnt_reg;
    logic [PASS_W-1:0]  pass_cnt_reg;
    logic [PASS_W-1:0]  pass_limit;
    logic [ROW_AW-1:0]  mirror_row;
    logic [COLUMNS-1:0] next_work;
    logic [COLUMNS-1:0] init_masked;
    logic               wr_en;
    logic [ROW_AW-1:0]  wr_addr;
    logic [COLUMNS-1:0] wr_data;
    logic [ROW_AW-1:0]  rd_addr;

    // channel state
    item_t              item_reg;
    logic [POS_W-1:0]   chan_pos_reg [CHANNELS];
    logic [CHANNELS-1:0] prev_clk_reg;
    logic [CNT_W-1:0]   active_reg;
    logic [AREA_W-1:0]  cpc_reg;
    logic [AREA_W-1:0]  acc_reg;
    logic [CH_AW-1:0]   chan_idx_reg;
    logic [AREA_W-1:0]  start_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               gate_ok_reg;
    logic [COL_AW-1:0]  bit_idx_reg;
    logic               gate_reg;
    result_t            result_reg;

    // frame, share and sample arithmetic
    logic [15:0]        clip_x;
    logic [15:0]        clip_y;
    logic [15:0]        clip_w;
    logic [15:0]        clip_h;
    logic [XW-1:0]      fx;
    logic [YW-1:0]      fy;
    logic [XW-1:0]      fw;
    logic [YW-1:0]      fh;
    logic [AREA_W-1:0]  area;
    logic [CNT_W-1:0]   count_sat;
    logic [CH_AW-1:0]   ch_idx;
    logic               rising;
    logic [POS_W-1:0]   cur_pos;
    logic [SUM_W-1:0]   pos_inc;
    logic [SUM_W-1:0]   new_pos;
    logic [SUM_W-1:0]   row_sum;
    logic [COL_SUM_W-1:0] col_sum;

    // divider
    logic               div_start;
    logic [AREA_W-1:0]  div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic               div_busy;
    logic [AREA_W-1:0]  div_quo;
    logic [DIVISOR_W-1:0] div_rem;

    function automatic logic [COLUMNS-1:0] next_row(
        input logic [COLUMNS-1:0] cur,
        input logic [RULE_W-1:0]  rule,
        input logic               short_mode
    );
        logic [COLUMNS-1:0] res;
        logic               l;
        logic               c;
        logic               r;
        int                 li;
        int                 ri;
        res = '0;
        for (int i = 0; i < COLUMNS; i++)
        begin
            li = (i == 0) ? (short_mode ? COLUMNS - 2 : COLUMNS - 1) : i - 1;
            ri = ((i == COLUMNS - 1) || (short_mode && (i == COLUMNS - 2))) ? 0 : i + 1;
            l = cur[COL_AW'(li)];
            c = cur[i];
            r = cur[COL_AW'(ri)];
            res[i] = rule[{l, c, r}];
        end
        if (short_mode)
        begin
            res[COLUMNS-1] = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [COLUMNS-1:0] reverse_row(input logic [COLUMNS-1:0] src);
        logic [COLUMNS-1:0] dst;
        dst = '0;
        for (int i = 0; i < COLUMNS; i++)
        begin
            dst[COLUMNS-1-i] = src[i];
        end
        return dst;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg       <= RULE_RESET;
            init_row_reg   <= '0;
            short_ring_reg <= 1'b0;
            iter_reg       <= '0;
            frame_x_reg    <= '0;
            frame_y_reg    <= '0;
            frame_w_reg    <= FRAME_W_W'(COLUMNS);
            frame_h_reg    <= FRAME_H_W'(ROWS);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_RULE:       rule_reg       <= cfg_data[RULE_W-1:0];
                REG_INIT_ROW:   init_row_reg   <= cfg_data[INIT_ROW_W-1:0];
                REG_SHORT_RING: short_ring_reg <= cfg_data[0];
                REG_ITERATIONS: iter_reg       <= cfg_data[ITER_W-1:0];
                REG_FRAME_X:    frame_x_reg    <= cfg_data[FRAME_X_W-1:0];
                REG_FRAME_Y:    frame_y_reg    <= cfg_data[FRAME_Y_W-1:0];
                REG_FRAME_W:    frame_w_reg    <= cfg_data[FRAME_W_W-1:0];
                REG_FRAME_H:    frame_h_reg    <= cfg_data[FRAME_H_W-1:0];
                default:        rule_reg       <= rule_reg;
            endcase
        end
    end

    // clipped frame
    always_comb
    begin
        clip_x = (16'(frame_x_reg) > 16'(COLUMNS)) ? 16'(COLUMNS) : 16'(frame_x_reg);
        clip_y = (16'(frame_y_reg) > 16'(ROWS)) ? 16'(ROWS) : 16'(frame_y_reg);
        clip_w = (16'(frame_w_reg) + clip_x > 16'(COLUMNS)) ?
                 16'(COLUMNS) - clip_x : 16'(frame_w_reg);
        clip_h = (16'(frame_h_reg) + clip_y > 16'(ROWS)) ?
                 16'(ROWS) - clip_y : 16'(frame_h_reg);
    end

    assign fx   = XW'(clip_x);
    assign fy   = YW'(clip_y);
    assign fw   = XW'(clip_w);
    assign fh   = YW'(clip_h);
    assign area = AREA_W'(AREA_W'(fw) * AREA_W'(fh));

    // pass limit and start row
    always_comb
    begin
        pass_limit = (16'(iter_reg) > 16'(MAX_ITERATIONS)) ?
                     PASS_W'(MAX_ITERATIONS) : PASS_W'(iter_reg);
        init_masked = init_row_reg[COLUMNS-1:0];
        if (short_ring_reg)
        begin
            init_masked[COLUMNS-1] = 1'b0;
        end
    end

    assign next_work  = next_row(row_work_reg, rule_reg, short_ring_reg);
    assign mirror_row = ROW_AW'(ROWS - 1) - row_cnt_reg;
    assign rd_val     = field_ok_reg ? rd_data_reg : '0;

    // channel bookkeeping
    assign count_sat = (item_reg.channel_count > 5'(CHANNELS)) ?
                       CNT_W'(CHANNELS) : CNT_W'(item_reg.channel_count);
    assign ch_idx    = item_reg.channel[CH_AW-1:0];
    assign cur_pos   = chan_pos_reg[ch_idx];
    assign rising    = item_reg.clock_high && !prev_clk_reg[ch_idx];
    assign pos_inc   = SUM_W'(cur_pos) + SUM_W'(1);

    // wrap inside the channel's share
    always_comb
    begin
        if ((pos_inc >= SUM_W'(start_reg)) &&
            ((pos_inc - SUM_W'(start_reg)) >= SUM_W'(cpc_reg)))
        begin
            new_pos = SUM_W'(start_reg);
        end
        else
        begin
            new_pos = pos_inc;
        end
    end

    // framed cell address
    assign row_sum = SUM_W'(div_quo) + SUM_W'(fy);
    assign col_sum = COL_SUM_W'(div_rem) + COL_SUM_W'(fx);

    // divider operand select
    always_comb
    begin
        div_start    = (cmd.op == OP_RS_DIV) || (cmd.op == OP_SM_DIV) ||
                       (cmd.op == OP_POS_DIV);
        div_dividend = area;
        div_divisor  = DIVISOR_W'(active_reg);
        if (cmd.op == OP_POS_DIV)
        begin
            div_dividend = AREA_W'(pos_reg);
            div_divisor  = DIVISOR_W'(fw);
        end
        else if (cmd.op == OP_RS_DIV)
        begin
            div_divisor = DIVISOR_W'(count_sat);
        end
    end

    eas_divider #(
        .DIVIDEND_W (AREA_W),
        .DIVISOR_W  (DIVISOR_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // memory port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = row_cnt_reg;
        wr_data = next_work;
        rd_addr = row_cnt_reg;
        unique case (cmd.op)
            OP_GEN_STEP:
            begin
                wr_en = 1'b1;
            end
            OP_FH_WRITE:
            begin
                wr_en   = 1'b1;
                wr_data = reverse_row(rd_val);
            end
            OP_FV_READ_B:
            begin
                rd_addr = mirror_row;
            end
            OP_FV_WRITE_A:
            begin
                wr_en   = 1'b1;
                wr_data = rd_val;
            end
            OP_FV_WRITE_B:
            begin
                wr_en   = 1'b1;
                wr_addr = mirror_row;
                wr_data = hold_reg;
            end
            OP_SM_READ:
            begin
                rd_addr = ROW_AW'(row_sum);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // field memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            field_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= field_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_ok_reg <= 1'b0;
            row_cnt_reg  <= '0;
            pass_cnt_reg <= '0;
            active_reg   <= '0;
            cpc_reg      <= '0;
            chan_idx_reg <= '0;
            prev_clk_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                chan_pos_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    row_cnt_reg <= '0;
                end
                OP_GEN_INIT:
                begin
                    field_ok_reg <= 1'b1;
                    pass_cnt_reg <= '0;
                    row_cnt_reg  <= '0;
                end
                OP_GEN_STEP:
                begin
                    row_cnt_reg <= row_cnt_reg + ROW_AW'(1);
                    if (status.row_last)
                    begin
                        row_cnt_reg  <= '0;
                        pass_cnt_reg <= pass_cnt_reg + PASS_W'(1);
                    end
                end
                OP_FH_WRITE, OP_FV_WRITE_B:
                begin
                    row_cnt_reg <= row_cnt_reg + ROW_AW'(1);
                end
                OP_RS_ZERO:
                begin
                    active_reg <= '0;
                    cpc_reg    <= '0;
                end
                OP_RS_DIV:
                begin
                    active_reg <= count_sat;
                end
                OP_RS_TAKE:
                begin
                    cpc_reg      <= div_quo;
                    chan_idx_reg <= '0;
                end
                OP_RS_POS:
                begin
                    chan_pos_reg[chan_idx_reg] <= POS_W'(acc_reg);
                    chan_idx_reg <= chan_idx_reg + CH_AW'(1);
                end
                OP_SM_TAKE:
                begin
                    cpc_reg <= div_quo;
                end
                OP_SM_STEP:
                begin
                    if (rising)
                    begin
                        chan_pos_reg[ch_idx] <= POS_W'(new_pos);
                    end
                    prev_clk_reg[ch_idx] <= item_reg.clock_high;
                end
                default:
                begin
                    field_ok_reg <= field_ok_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:       item_reg     <= item;
            OP_GEN_INIT:   row_work_reg <= init_masked;
            OP_GEN_STEP:   row_work_reg <= next_work;
            OP_FV_READ_B:  hold_reg     <= rd_val;
            OP_RS_TAKE:    acc_reg      <= '0;
            OP_RS_POS:     acc_reg      <= acc_reg + cpc_reg;
            OP_SM_TAKE:    start_reg    <= AREA_W'(AREA_W'(item_reg.channel) * div_quo);
            OP_SM_STEP:
            begin
                pos_reg  <= rising ? POS_W'(new_pos) : cur_pos;
                gate_reg <= 1'b0;
            end
            OP_SM_READ:
            begin
                gate_ok_reg <= (div_quo < AREA_W'(fh)) && (row_sum < SUM_W'(ROWS)) &&
                               (col_sum < COL_SUM_W'(COLUMNS));
                bit_idx_reg <= COL_AW'(col_sum);
            end
            OP_SM_BIT:     gate_reg     <= gate_ok_reg && rd_val[bit_idx_reg];
            OP_RESULT:
            begin
                result_reg.out_channel     <= item_reg.channel;
                result_reg.gate            <= gate_reg;
                result_reg.trigger         <= gate_reg && item_reg.clock_high;
                result_reg.end_of_sequence <= (pos_reg == '0) && item_reg.clock_high;
            end
            default:       hold_reg     <= hold_reg;
        endcase
    end

    // status back to the controller
    always_comb
    begin
        status.row_last    = (row_cnt_reg == ROW_AW'(ROWS - 1));
        status.gen_last    = status.row_last && (pass_cnt_reg == pass_limit);
        status.pair_last   = (row_cnt_reg == ROW_AW'(ROWS / 2 - 1));
        status.count_zero  = (count_sat == '0);
        status.div_busy    = div_busy;
        status.chan_last   = ((CNT_W'(chan_idx_reg) + CNT_W'(1)) == active_reg);
        status.sample_ok   = (active_reg != '0) &&
                             (5'(item_reg.channel) < 5'(active_reg));
        status.frame_empty = (fw == '0) || (fh == '0);
    end

    assign result = result_reg;

endmodule

[sv/eas_controller.sv]
module eas_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  eas_pkg::item_t      item,
    output logic                item_stall,
    output logic                result_valid,
    input  logic                result_stall,
    input  eas_pkg::dp_status_t status,
    output eas_pkg::dp_cmd_t    cmd
);
    import eas_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GEN_INIT,
        ST_GEN_RUN,
        ST_FH_RD,
        ST_FH_WR,
        ST_FV_RA,
        ST_FV_RB,
        ST_FV_WA,
        ST_FV_WB,
        ST_RS_START,
        ST_RS_WAIT,
        ST_RS_TAKE,
        ST_RS_POS,
        ST_SM_CHECK,
        ST_SM_WAIT,
        ST_SM_TAKE,
        ST_SM_STEP,
        ST_SM_PDIV,
        ST_SM_PWAIT,
        ST_SM_READ,
        ST_SM_BIT,
        ST_SM_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    dp_op_t op;

    // next state and datapath command
    always_comb
    begin
        state_next        = state_reg;
        op                = OP_NONE;
        result_valid_next = result_valid_reg && result_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    op = OP_LOAD;
                    case (kind_t'(item.kind))
                        KIND_GENERATE: state_next = ST_GEN_INIT;
                        KIND_FLIP_H:   state_next = ST_FH_RD;
                        KIND_FLIP_V:   state_next = ST_FV_RA;
                        KIND_RESTART:  state_next = ST_RS_START;
                        KIND_SAMPLE:   state_next = ST_SM_CHECK;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_GEN_INIT:
            begin
                op         = OP_GEN_INIT;
                state_next = ST_GEN_RUN;
            end
            ST_GEN_RUN:
            begin
                op = OP_GEN_STEP;
                if (status.gen_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FH_RD:
            begin
                op         = OP_FH_READ;
                state_next = ST_FH_WR;
            end
            ST_FH_WR:
            begin
                op         = OP_FH_WRITE;
                state_next = status.row_last ? ST_IDLE : ST_FH_RD;
            end
            ST_FV_RA:
            begin
                op         = OP_FV_READ_A;
                state_next = ST_FV_RB;
            end
            ST_FV_RB:
            begin
                op         = OP_FV_READ_B;
                state_next = ST_FV_WA;
            end
            ST_FV_WA:
            begin
                op         = OP_FV_WRITE_A;
                state_next = ST_FV_WB;
            end
            ST_FV_WB:
            begin
                op         = OP_FV_WRITE_B;
                state_next = status.pair_last ? ST_IDLE : ST_FV_RA;
            end
            ST_RS_START:
            begin
                if (status.count_zero)
                begin
                    op         = OP_RS_ZERO;
                    state_next = ST_IDLE;
                end
                else
                begin
                    op         = OP_RS_DIV;
                    state_next = ST_RS_WAIT;
                end
            end
            ST_RS_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_RS_TAKE;
                end
            end
            ST_RS_TAKE:
            begin
                op         = OP_RS_TAKE;
                state_next = ST_RS_POS;
            end
            ST_RS_POS:
            begin
                op = OP_RS_POS;
                if (status.chan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SM_CHECK:
            begin
                if (status.sample_ok)
                begin
                    op         = OP_SM_DIV;
                    state_next = ST_SM_WAIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SM_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_SM_TAKE;
                end
            end
            ST_SM_TAKE:
            begin
                op         = OP_SM_TAKE;
                state_next = ST_SM_STEP;
            end
            ST_SM_STEP:
            begin
                op         = OP_SM_STEP;
                state_next = status.frame_empty ? ST_SM_OUT : ST_SM_PDIV;
            end
            ST_SM_PDIV:
            begin
                op         = OP_POS_DIV;
                state_next = ST_SM_PWAIT;
            end
            ST_SM_PWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_SM_READ;
                end
            end
            ST_SM_READ:
            begin
                op         = OP_SM_READ;
                state_next = ST_SM_BIT;
            end
            ST_SM_BIT:
            begin
                op         = OP_SM_BIT;
                state_next = ST_SM_OUT;
            end
            ST_SM_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    op                = OP_RESULT;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign cmd.op       = op;
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

[sv/eas_checker.sv]
`include "elementary_automaton_sequencer_core_macros.svh"

module eas_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input eas_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input eas_pkg::result_t result
);
    import eas_pkg::*;

    // a stalled result beat holds
    `EAS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

    // trigger only with the gate set
    `EAS_ASSERT_IMPLY(a_trigger_gate, result_valid, !result.trigger || result.gate)

    // every accepted beat of a known kind leaves the block busy in the next cycle
    `EAS_ASSERT_NEXT(a_accept_busy, item_valid && !item_stall && (item.kind <= KIND_SAMPLE), item_stall)

    // only clock samples produce a result
    `EAS_ASSERT_NEXT(a_no_result, item_valid && !item_stall && !result_valid && (item.kind != KIND_SAMPLE), !result_valid)

endmodule

bind elementary_automaton_sequencer_core eas_checker u_eas_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
